>>> sv/jfr_pkg.sv
package jfr_pkg;

    // frame geometry
    localparam int CHANNELS      = 6;
    localparam int BUFFER_BYTES  = 64;
    localparam int PAYLOAD_BYTES = CHANNELS * 4;
    localparam int FRAME_LEN     = PAYLOAD_BYTES + 4;

    // index width covers the buffer capacity and the full frame length
    localparam int IDX_MAX = (BUFFER_BYTES > FRAME_LEN) ? BUFFER_BYTES : FRAME_LEN;
    localparam int IDX_W   = $clog2(IDX_MAX + 1);
    localparam int CH_W    = $clog2(CHANNELS);

    // footer bytes, oldest first
    localparam logic [7:0] FOOT0 = 8'h00;
    localparam logic [7:0] FOOT1 = 8'h00;
    localparam logic [7:0] FOOT2 = 8'h80;
    localparam logic [7:0] FOOT3 = 8'h7F;

    // channels routed to the output
    localparam int IDX_J2 = 1;
    localparam int IDX_J4 = 3;
    localparam int IDX_J5 = 4;

    localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_ENABLE  = 1'b0,
        CFG_TIMEOUT = 1'b1
    } cfg_index_t;

    // item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // one result beat
    typedef struct packed {
        logic        frame_dropped;
        logic        frame_accepted;
        logic        online;
        logic [31:0] frame_total;
        logic [31:0] joint_5_bits;
        logic [31:0] joint_4_bits;
        logic [31:0] joint_2_bits;
    } result_t;

endpackage

>>> sv/justfloat_frame_receiver.sv
// output: each result beat is registered, in the skid register while the output stalls
// throughput: one input beat per cycle while the skid is free; a two-deep output stage
//   (register plus skid) keeps input open while one finished result waits downstream
// reset: rst_n is asynchronous, active low; clears index, counters, channel
//   words, frame-seen flag and output valids; enable 0, timeout 100 ms
module justfloat_frame_receiver
    import jfr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] byte_value
    input  logic         s_tuser,   // [0] kind
    // output stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // joint_2_bits, joint_4_bits, joint_5_bits, frame_total
    output logic [2:0]   m_tuser,   // online, frame_accepted, frame_dropped
    // configuration writes
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_wdata
);

    logic              enable_reg;
    logic [15:0]       timeout_reg;

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [7:0]        win_reg [3];
    logic              ok_reg, ok_next;
    logic [31:0]       stage_reg [CHANNELS];
    logic [31:0]       joint_reg [CHANNELS];
    logic              seen_reg, seen_next;
    logic [31:0]       good_reg, good_next;
    logic [16:0]       elapsed_reg, elapsed_next;

    result_t           out_reg, skid_reg, res;
    logic              out_valid_reg, skid_valid_reg;

    logic              s_take, m_take, is_byte;
    logic [IDX_W-1:0]  pos, n;
    logic              footer, bad_word, in_data, accept_frame, drop_frame;

    assign s_tready = !skid_valid_reg;
    assign s_take   = s_tvalid && s_tready;
    assign m_take   = out_valid_reg && m_tready;
    assign is_byte  = (s_tuser == KIND_BYTE);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ENABLE:  enable_reg  <= cfg_wdata[0];
                CFG_TIMEOUT: timeout_reg <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    // byte position, footer window and finite check
    always_comb
    begin
        pos      = (idx_reg >= IDX_W'(BUFFER_BYTES)) ? '0 : idx_reg;
        n        = pos + IDX_W'(1);
        in_data  = (pos < IDX_W'(PAYLOAD_BYTES));
        footer   = (n >= IDX_W'(4)) && (win_reg[2] == FOOT0) && (win_reg[1] == FOOT1)
                   && (win_reg[0] == FOOT2) && (s_tdata == FOOT3);
        bad_word = in_data && (pos[1:0] == 2'd3) && (s_tdata[6:0] == 7'h7F)
                   && win_reg[0][7];
        ok_next  = ((pos == '0) ? 1'b1 : ok_reg) && !bad_word;
        accept_frame = is_byte && footer && (n == IDX_W'(FRAME_LEN)) && ok_next;
        drop_frame   = is_byte && footer && !accept_frame;
        idx_next = footer ? '0 : n;
    end

    // frame bookkeeping and timer
    always_comb
    begin
        seen_next    = seen_reg;
        good_next    = good_reg;
        elapsed_next = elapsed_reg;
        if (!is_byte)
        begin
            if (elapsed_reg < ELAPSED_MAX)
                elapsed_next = elapsed_reg + 17'd1;
        end
        else if (accept_frame)
        begin
            seen_next    = 1'b1;
            good_next    = good_reg + 32'd1;
            elapsed_next = '0;
        end
    end

    // result of the beat being taken
    always_comb
    begin
        res.online         = enable_reg && seen_next && (elapsed_next <= {1'b0, timeout_reg});
        res.frame_accepted = accept_frame;
        res.frame_dropped  = drop_frame;
        res.frame_total    = good_next;
        res.joint_2_bits   = accept_frame ? stage_reg[IDX_J2] : joint_reg[IDX_J2];
        res.joint_4_bits   = accept_frame ? stage_reg[IDX_J4] : joint_reg[IDX_J4];
        res.joint_5_bits   = accept_frame ? stage_reg[IDX_J5] : joint_reg[IDX_J5];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            seen_reg    <= 1'b0;
            good_reg    <= '0;
            elapsed_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
                joint_reg[i] <= '0;
        end
        else if (s_take)
        begin
            seen_reg    <= seen_next;
            good_reg    <= good_next;
            elapsed_reg <= elapsed_next;
            if (is_byte)
                idx_reg <= idx_next;
            if (accept_frame)
            begin
                for (int i = 0; i < CHANNELS; i++)
                    joint_reg[i] <= stage_reg[i];
            end
        end
    end

    // byte window, running finite flag and word staging
    always_ff @(posedge clk)
    begin
        if (s_take && is_byte)
        begin
            win_reg[2] <= win_reg[1];
            win_reg[1] <= win_reg[0];
            win_reg[0] <= s_tdata;
            ok_reg     <= ok_next;
            if (in_data)
                stage_reg[pos[CH_W+1:2]][{pos[1:0], 3'b000} +: 8] <= s_tdata;
        end
    end

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || m_take)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                    out_valid_reg <= s_take;
            end
            else if (s_take)
                skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_take)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (s_take)
                out_reg <= res;
        end
        else if (s_take)
            skid_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.frame_total, out_reg.joint_5_bits,
                       out_reg.joint_4_bits, out_reg.joint_2_bits};
    assign m_tuser  = {out_reg.frame_dropped, out_reg.frame_accepted, out_reg.online};

    // checks
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while the output register is empty");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.frame_accepted && out_reg.frame_dropped))
        else $error("frame both accepted and dropped");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (s_take && accept_frame) |=> (good_reg == $past(good_reg) + 32'd1))
        else $error("accepted frame not counted");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_W'(BUFFER_BYTES))
        else $error("write index beyond buffer capacity");

    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready && !skid_valid_reg && s_take) |=> skid_valid_reg)
        else $error("beat taken while output stalled was not held");

endmodule
